### rtl/fcm_pkg.sv
// Shared types, constants and helpers for the chain table manager.
package fcm_pkg;

    localparam int TABLE_ENTRIES = 4096;
    localparam int BLK_W         = 12;
    localparam int ENT_W         = BLK_W + 1;
    localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
    localparam int USABLE        = (TABLE_ENTRIES < 4096) ? TABLE_ENTRIES : 4096;
    localparam int QDEPTH        = 2;
    localparam int QPTR_W        = $clog2(QDEPTH);

    // entry: all zero = free, bit 12 set = end of chain, else next block
    localparam logic [ENT_W-1:0] ENT_FREE = '0;
    localparam logic [ENT_W-1:0] ENT_END  = {1'b1, {BLK_W{1'b0}}};

    localparam logic [BLK_W-1:0]  LAST_BLK   = BLK_W'(USABLE - 1);
    localparam logic [BLK_W:0]    USABLE_CNT = (BLK_W + 1)'(USABLE);
    localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(TABLE_ENTRIES - 1);

    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_FORMAT = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_A_PCHK,
        S_A_SCAN,
        S_A_LINK,
        S_F_CHK,
        S_F_CLR,
        S_L_RD
    } t_state;

    typedef struct packed {
        t_op              op;
        logic [BLK_W-1:0] start;
        logic [BLK_W-1:0] prev;
        logic             has_prev;
    } t_cmd;

    typedef struct packed {
        logic [BLK_W-1:0] blk;
        logic             at_end;
        logic [BLK_W-1:0] freed;
        t_status          status;
    } t_result;

    function automatic logic in_range(input logic [BLK_W-1:0] b);
        return {1'b0, b} < USABLE_CNT;
    endfunction

    function automatic logic [ADDR_W-1:0] to_addr(input logic [BLK_W-1:0] b);
        return ADDR_W'(b);
    endfunction

endpackage

### rtl/fcm_front.sv
// Request intake: decodes stream requests into commands and queues them.
module fcm_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [31:0]         i_s_tdata,
    input  logic [1:0]          i_s_tuser,
    output logic                o_cmd_valid,
    output fcm_pkg::t_cmd       o_cmd,
    input  logic                i_cmd_pop
);

    fcm_pkg::t_cmd                 r_q [fcm_pkg::QDEPTH];
    logic [fcm_pkg::QPTR_W-1:0]    r_wp, n_wp;
    logic [fcm_pkg::QPTR_W-1:0]    r_rp, n_rp;
    logic [fcm_pkg::QPTR_W:0]      r_cnt, n_cnt;
    fcm_pkg::t_cmd                 w_dec;
    logic                          w_push;
    logic                          w_pop;

    always_comb begin
        w_dec.op       = fcm_pkg::t_op'(i_s_tuser);
        w_dec.start    = i_s_tdata[11:0];
        w_dec.prev     = i_s_tdata[23:12];
        w_dec.has_prev = i_s_tdata[24];
    end

    assign o_s_tready  = (r_cnt != (fcm_pkg::QPTR_W + 1)'(fcm_pkg::QDEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];
    assign w_push      = i_s_tvalid && o_s_tready;
    assign w_pop       = i_cmd_pop && o_cmd_valid;

    always_comb begin
        n_wp  = w_push ? r_wp + 1'b1 : r_wp;
        n_rp  = w_pop ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt + (fcm_pkg::QPTR_W + 1)'(w_push) - (fcm_pkg::QPTR_W + 1)'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_dec;
        end
    end

endmodule

### rtl/fcm_back.sv
// Command engine: owns the link table and runs allocate, free, lookup and format.
module fcm_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  fcm_pkg::t_cmd       i_cmd,
    output logic                o_cmd_pop,
    output logic                o_res_valid,
    output fcm_pkg::t_result    o_res,
    input  logic                i_res_ready
);

    logic [fcm_pkg::ENT_W-1:0]  mem [fcm_pkg::TABLE_ENTRIES];
    logic [fcm_pkg::ENT_W-1:0]  r_rd;

    fcm_pkg::t_state            r_state, n_state;
    fcm_pkg::t_cmd              r_cmd, n_cmd;
    logic [fcm_pkg::BLK_W-1:0]  r_idx, n_idx;
    logic [fcm_pkg::BLK_W-1:0]  r_cur, n_cur;
    logic [fcm_pkg::BLK_W-1:0]  r_found, n_found;
    logic [fcm_pkg::BLK_W:0]    r_n, n_n;
    logic [fcm_pkg::BLK_W:0]    r_left, n_left;
    logic [fcm_pkg::ADDR_W-1:0] r_clr, n_clr;
    logic                       r_fmt, n_fmt;
    logic                       r_out_valid, n_out_valid;
    fcm_pkg::t_result           r_out, n_out;

    logic                       w_we;
    logic [fcm_pkg::ADDR_W-1:0] w_waddr;
    logic [fcm_pkg::ENT_W-1:0]  w_wdata;
    logic [fcm_pkg::ADDR_W-1:0] w_raddr;
    logic [fcm_pkg::BLK_W-1:0]  w_next;
    logic                       w_fin;
    fcm_pkg::t_result           w_res;

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;
    assign w_next      = r_rd[fcm_pkg::BLK_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_idx       = r_idx;
        n_cur       = r_cur;
        n_found     = r_found;
        n_n         = r_n;
        n_left      = r_left;
        n_clr       = r_clr;
        n_fmt       = r_fmt;
        n_out_valid = r_out_valid && !i_res_ready;
        n_out       = r_out;
        w_we        = 1'b0;
        w_waddr     = r_clr;
        w_wdata     = fcm_pkg::ENT_FREE;
        w_raddr     = fcm_pkg::to_addr(r_idx);
        o_cmd_pop   = 1'b0;
        w_fin       = 1'b0;
        w_res       = '{blk: '0, at_end: 1'b0, freed: '0, status: fcm_pkg::ST_OK};

        case (r_state)
            fcm_pkg::S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                n_clr   = r_clr + 1'b1;
                if (r_clr == fcm_pkg::LAST_ADDR) begin
                    n_fmt   = 1'b0;
                    n_state = fcm_pkg::S_IDLE;
                    w_fin   = r_fmt;
                end
            end
            fcm_pkg::S_IDLE: begin
                if (i_cmd_valid && !r_out_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    case (i_cmd.op)
                        fcm_pkg::OP_ALLOC: begin
                            if (i_cmd.has_prev) begin
                                if (i_cmd.prev == '0 || !fcm_pkg::in_range(i_cmd.prev)) begin
                                    w_fin        = 1'b1;
                                    w_res.status = fcm_pkg::ST_BAD;
                                end else begin
                                    w_raddr = fcm_pkg::to_addr(i_cmd.prev);
                                    n_state = fcm_pkg::S_A_PCHK;
                                end
                            end else begin
                                n_idx   = fcm_pkg::BLK_W'(1);
                                w_raddr = fcm_pkg::ADDR_W'(1);
                                n_state = fcm_pkg::S_A_SCAN;
                            end
                        end
                        fcm_pkg::OP_FREE: begin
                            if (i_cmd.start == '0 || !fcm_pkg::in_range(i_cmd.start)) begin
                                w_fin        = 1'b1;
                                w_res.status = fcm_pkg::ST_BAD;
                            end else begin
                                w_raddr = fcm_pkg::to_addr(i_cmd.start);
                                n_cur   = i_cmd.start;
                                n_n     = '0;
                                n_state = fcm_pkg::S_F_CHK;
                            end
                        end
                        fcm_pkg::OP_LOOKUP: begin
                            if (!fcm_pkg::in_range(i_cmd.start)) begin
                                w_fin        = 1'b1;
                                w_res.status = fcm_pkg::ST_BAD;
                            end else if (i_cmd.start == '0) begin
                                // entry 0 is the fixed end marker
                                w_fin        = 1'b1;
                                w_res.at_end = 1'b1;
                            end else begin
                                w_raddr = fcm_pkg::to_addr(i_cmd.start);
                                n_state = fcm_pkg::S_L_RD;
                            end
                        end
                        fcm_pkg::OP_FORMAT: begin
                            n_clr   = '0;
                            n_fmt   = 1'b1;
                            n_state = fcm_pkg::S_CLEAR;
                        end
                        default: begin
                            w_fin        = 1'b1;
                            w_res.status = fcm_pkg::ST_BAD;
                        end
                    endcase
                end
            end
            fcm_pkg::S_A_PCHK: begin
                if (r_rd == fcm_pkg::ENT_FREE) begin
                    w_fin        = 1'b1;
                    w_res.status = fcm_pkg::ST_BAD;
                end else begin
                    n_idx   = fcm_pkg::BLK_W'(1);
                    w_raddr = fcm_pkg::ADDR_W'(1);
                    n_state = fcm_pkg::S_A_SCAN;
                end
            end
            fcm_pkg::S_A_SCAN: begin
                // one entry per cycle; read of the next entry overlaps the check
                if (r_rd == fcm_pkg::ENT_FREE) begin
                    w_we    = 1'b1;
                    w_waddr = fcm_pkg::to_addr(r_idx);
                    w_wdata = fcm_pkg::ENT_END;
                    n_found = r_idx;
                    if (r_cmd.has_prev) begin
                        n_state = fcm_pkg::S_A_LINK;
                    end else begin
                        w_fin     = 1'b1;
                        w_res.blk = r_idx;
                    end
                end else if (r_idx == fcm_pkg::LAST_BLK) begin
                    w_fin        = 1'b1;
                    w_res.status = fcm_pkg::ST_FULL;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    w_raddr = fcm_pkg::to_addr(r_idx + 1'b1);
                end
            end
            fcm_pkg::S_A_LINK: begin
                w_we      = 1'b1;
                w_waddr   = fcm_pkg::to_addr(r_cmd.prev);
                w_wdata   = {1'b0, r_found};
                w_fin     = 1'b1;
                w_res.blk = r_found;
            end
            fcm_pkg::S_F_CHK: begin
                if (r_rd == fcm_pkg::ENT_FREE) begin
                    w_fin        = 1'b1;
                    w_res.status = fcm_pkg::ST_BAD;
                end else if (r_rd == fcm_pkg::ENT_END) begin
                    n_left  = r_n + 1'b1;
                    n_cur   = r_cmd.start;
                    w_raddr = fcm_pkg::to_addr(r_cmd.start);
                    n_state = fcm_pkg::S_F_CLR;
                end else if ((r_n + 1'b1) == fcm_pkg::USABLE_CNT || w_next == '0
                             || !fcm_pkg::in_range(w_next)) begin
                    // too long means the chain loops
                    w_fin        = 1'b1;
                    w_res.status = fcm_pkg::ST_BAD;
                end else begin
                    n_n     = r_n + 1'b1;
                    n_cur   = w_next;
                    w_raddr = fcm_pkg::to_addr(w_next);
                end
            end
            fcm_pkg::S_F_CLR: begin
                w_we    = 1'b1;
                w_waddr = fcm_pkg::to_addr(r_cur);
                w_wdata = fcm_pkg::ENT_FREE;
                n_left  = r_left - 1'b1;
                if (r_left == (fcm_pkg::BLK_W + 1)'(1)) begin
                    w_fin       = 1'b1;
                    w_res.freed = fcm_pkg::BLK_W'(r_n + 1'b1);
                end else begin
                    n_cur   = w_next;
                    w_raddr = fcm_pkg::to_addr(w_next);
                end
            end
            fcm_pkg::S_L_RD: begin
                w_fin = 1'b1;
                if (r_rd == fcm_pkg::ENT_FREE) begin
                    w_res.status = fcm_pkg::ST_BAD;
                end else if (r_rd == fcm_pkg::ENT_END) begin
                    w_res.at_end = 1'b1;
                end else begin
                    w_res.blk = w_next;
                end
            end
            default: begin
                n_state = fcm_pkg::S_IDLE;
            end
        endcase

        if (w_fin) begin
            n_out_valid = 1'b1;
            n_out       = w_res;
            n_state     = fcm_pkg::S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fcm_pkg::S_CLEAR;
            r_clr       <= '0;
            r_fmt       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_fmt       <= n_fmt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_idx   <= n_idx;
        r_cur   <= n_cur;
        r_found <= n_found;
        r_n     <= n_n;
        r_left  <= n_left;
        r_out   <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rd <= mem[w_raddr];
    end

endmodule

### rtl/fat_chain_manager.sv
// Lookup reads one entry; allocate scans up from block 1 for the lowest free block, then
// links the previous block if given; free checks the chain, then clears it; format clears the table.
// One request is in the engine at a time; two more queue at the input meanwhile.
// Reset (synchronous, active low) starts a clearing pass over the whole table;
// requests queue but run only after it.
// Top level of the chain table manager.
module fat_chain_manager (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // start_block[11:0], prev_block[23:12], has_prev[24]
    input  logic [1:0]  i_s_tuser,   // req_type[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata    // block_out[11:0], at_end[12], freed_count[24:13],
                                     // status[26:25]
);

    logic             w_cmd_valid;
    fcm_pkg::t_cmd    w_cmd;
    logic             w_cmd_pop;
    fcm_pkg::t_result w_res;

    fcm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    fcm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .o_res_valid (o_m_tvalid),
        .o_res       (w_res),
        .i_res_ready (i_m_tready)
    );

    assign o_m_tdata = {5'b0, w_res.status, w_res.freed, w_res.at_end, w_res.blk};

endmodule

### sim/fat_chain_manager_test.sv
// Self-checking testbench for the chain table manager: directed and random requests.
`timescale 1ns / 100ps

module fat_chain_manager_test;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata  = '0;  // start_block[11:0], prev_block[23:12], has_prev[24]
    logic [1:0]  i_s_tuser  = '0;  // req_type[1:0]
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;        // block_out[11:0], at_end[12], freed_count[24:13],
                                   // status[26:25]

    fat_chain_manager DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [fcm_pkg::ENT_W-1:0] fat_model [fcm_pkg::USABLE];
    fcm_pkg::t_result          expected_results [$];
    int                        mismatches = 0;
    int                        burst_left = 0;
    int                        stall_mode = 0;
    int                        cycle_cnt  = 0;
    int                        chain_head [$];
    int                        chain_tail [$];

    task automatic report(input string what);
        $display("mismatch @%0t: %s", $realtime, what);
        mismatches++;
    endtask

    function automatic void format_model();
        foreach (fat_model[i]) fat_model[i] = fcm_pkg::ENT_FREE;
        fat_model[0] = fcm_pkg::ENT_END;
    endfunction

    // Applies one request to the table copy and returns the result it yields.
    function automatic fcm_pkg::t_result apply_request(
        input fcm_pkg::t_op op, input logic [fcm_pkg::BLK_W-1:0] sb,
        input logic [fcm_pkg::BLK_W-1:0] pb, input logic hp);
        fcm_pkg::t_result          r;
        int                        found;
        int                        n;
        int                        cur;
        bit                        chain_good;
        logic [fcm_pkg::ENT_W-1:0] e;
        r = '0;
        r.status = fcm_pkg::ST_OK;
        case (op)
            fcm_pkg::OP_ALLOC: begin
                if (hp && (pb == 0 || int'(pb) >= fcm_pkg::USABLE
                           || fat_model[pb] == fcm_pkg::ENT_FREE)) begin
                    r.status = fcm_pkg::ST_BAD;
                end else begin
                    found = 0;
                    for (int i = 1; i < fcm_pkg::USABLE; i++) begin
                        if (fat_model[i] == fcm_pkg::ENT_FREE) begin
                            found = i;
                            break;
                        end
                    end
                    if (found == 0) begin
                        r.status = fcm_pkg::ST_FULL;
                    end else begin
                        fat_model[found] = fcm_pkg::ENT_END;
                        if (hp) fat_model[pb] = {1'b0, fcm_pkg::BLK_W'(found)};
                        r.blk = fcm_pkg::BLK_W'(found);
                    end
                end
            end
            fcm_pkg::OP_FREE: begin
                // whole chain is checked before anything is cleared
                cur = sb;
                n = 0;
                chain_good = 0;
                while (n < fcm_pkg::USABLE) begin
                    if (cur == 0 || cur >= fcm_pkg::USABLE) break;
                    e = fat_model[cur];
                    if (e == fcm_pkg::ENT_FREE) break;
                    n++;
                    if (e == fcm_pkg::ENT_END) begin
                        chain_good = 1;
                        break;
                    end
                    cur = e[fcm_pkg::BLK_W-1:0];
                end
                if (chain_good) begin
                    cur = sb;
                    for (int k = 0; k < n; k++) begin
                        e = fat_model[cur];
                        fat_model[cur] = fcm_pkg::ENT_FREE;
                        cur = e[fcm_pkg::BLK_W-1:0];
                    end
                    r.freed = fcm_pkg::BLK_W'(n);
                end else begin
                    r.status = fcm_pkg::ST_BAD;
                end
            end
            fcm_pkg::OP_LOOKUP: begin
                if (int'(sb) >= fcm_pkg::USABLE || fat_model[sb] == fcm_pkg::ENT_FREE)
                    r.status = fcm_pkg::ST_BAD;
                else if (fat_model[sb] == fcm_pkg::ENT_END) r.at_end = 1'b1;
                else r.blk = fat_model[sb][fcm_pkg::BLK_W-1:0];
            end
            default: format_model();
        endcase
        return r;
    endfunction

    task automatic send_req(input fcm_pkg::t_op op, input logic [fcm_pkg::BLK_W-1:0] sb,
                            input logic [fcm_pkg::BLK_W-1:0] pb, input logic hp,
                            output fcm_pkg::t_result r);
        int gap;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {7'b0, hp, pb, sb};
        i_s_tuser  <= op;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        r = apply_request(op, sb, pb, hp);
        expected_results.push_back(r);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Receiver: stall pattern switches at random between four modes.
    always @(posedge i_clk) begin
        fcm_pkg::t_result got;
        fcm_pkg::t_result want;
        cycle_cnt++;
        if (o_m_tvalid && i_m_tready) begin
            got.blk    = o_m_tdata[11:0];
            got.at_end = o_m_tdata[12];
            got.freed  = o_m_tdata[24:13];
            got.status = fcm_pkg::t_status'(o_m_tdata[26:25]);
            if (expected_results.size() == 0) begin
                report("result with no request pending");
            end else begin
                want = expected_results.pop_front();
                if (got.blk != want.blk)
                    report($sformatf("block_out %0d, want %0d", got.blk, want.blk));
                if (got.at_end != want.at_end)
                    report($sformatf("at_end %0b, want %0b", got.at_end, want.at_end));
                if (got.freed != want.freed)
                    report($sformatf("freed_count %0d, want %0d", got.freed, want.freed));
                if (got.status != want.status)
                    report($sformatf("status %0d, want %0d", got.status, want.status));
            end
        end
        if (cycle_cnt % 256 == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: i_m_tready <= 1'b1;
            1: i_m_tready <= $urandom_range(0, 1);
            2: i_m_tready <= ($urandom_range(0, 3) == 0);
            default: i_m_tready <= cycle_cnt[3];
        endcase
    end

    task automatic test_special_cases();
        fcm_pkg::t_result r;
        send_req(fcm_pkg::OP_LOOKUP, 12'd0,   12'd0,   1'b0, r);  // reserved entry reads as end
        send_req(fcm_pkg::OP_LOOKUP, 12'd5,   12'd0,   1'b0, r);
        send_req(fcm_pkg::OP_LOOKUP, 12'hFFF, 12'd0,   1'b0, r);
        send_req(fcm_pkg::OP_FREE,   12'd0,   12'd0,   1'b0, r);
        send_req(fcm_pkg::OP_FREE,   12'd7,   12'd0,   1'b0, r);
        send_req(fcm_pkg::OP_ALLOC,  12'd0,   12'd0,   1'b1, r);  // prev 0
        send_req(fcm_pkg::OP_ALLOC,  12'd0,   12'd9,   1'b1, r);  // prev free
        send_req(fcm_pkg::OP_ALLOC,  12'hFFF, 12'hFFF, 1'b1, r);
        send_req(fcm_pkg::OP_ALLOC,  12'hFFF, 12'hFFF, 1'b0, r);  // block 1
        send_req(fcm_pkg::OP_ALLOC,  12'd0,   12'd1,   1'b1, r);  // 1 -> 2
        send_req(fcm_pkg::OP_ALLOC,  12'd0,   12'd1,   1'b1, r);  // relink 1 -> 3
        send_req(fcm_pkg::OP_LOOKUP, 12'd1,   12'd0,   1'b0, r);
        send_req(fcm_pkg::OP_LOOKUP, 12'd2,   12'd0,   1'b0, r);
        send_req(fcm_pkg::OP_FREE,   12'd2,   12'd0,   1'b0, r);
        send_req(fcm_pkg::OP_FREE,   12'd3,   12'd0,   1'b0, r);
        send_req(fcm_pkg::OP_FREE,   12'd1,   12'd0,   1'b0, r);  // chain runs into a free entry
        send_req(fcm_pkg::OP_ALLOC,  12'd0,   12'd0,   1'b0, r);
        send_req(fcm_pkg::OP_FORMAT, 12'hABC, 12'h543, 1'b1, r);
        send_req(fcm_pkg::OP_LOOKUP, 12'd1,   12'd0,   1'b0, r);
        drain();
    endtask

    // One long chain from a clean table, then freeing it all.
    task automatic test_long_chain();
        fcm_pkg::t_result          r;
        logic [fcm_pkg::BLK_W-1:0] last;
        send_req(fcm_pkg::OP_FORMAT, 12'd0, 12'd0, 1'b0, r);
        send_req(fcm_pkg::OP_ALLOC,  12'd0, 12'd0, 1'b0, r);
        last = r.blk;
        for (int i = 2; i <= 300; i++) begin
            send_req(fcm_pkg::OP_ALLOC, 12'd0, last, 1'b1, r);
            last = r.blk;
        end
        send_req(fcm_pkg::OP_LOOKUP, 12'd299, 12'd0, 1'b0, r);
        send_req(fcm_pkg::OP_LOOKUP, 12'd300, 12'd0, 1'b0, r);
        send_req(fcm_pkg::OP_FREE,   12'd1,   12'd0, 1'b0, r);
        send_req(fcm_pkg::OP_LOOKUP, 12'd300, 12'd0, 1'b0, r);
        drain();
    endtask

    function automatic logic [fcm_pkg::BLK_W-1:0] any_block();
        return ($urandom_range(0, 9) == 0) ? fcm_pkg::BLK_W'($urandom)
                                           : fcm_pkg::BLK_W'($urandom_range(0, 200));
    endfunction

    task automatic test_random_traffic(input int count);
        fcm_pkg::t_result r;
        int               pick;
        int               idx;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            idx = (chain_head.size() != 0) ? $urandom_range(0, chain_head.size() - 1) : -1;
            if (n == count / 2) drain();
            if (pick < 2) begin
                send_req(fcm_pkg::OP_FORMAT, fcm_pkg::BLK_W'($urandom),
                         fcm_pkg::BLK_W'($urandom), 1'($urandom), r);
                chain_head.delete();
                chain_tail.delete();
            end else if (pick < 45 && chain_head.size() < 12) begin
                if (idx >= 0 && $urandom_range(0, 9) < 6) begin
                    send_req(fcm_pkg::OP_ALLOC, any_block(),
                             fcm_pkg::BLK_W'(chain_tail[idx]), 1'b1, r);
                    if (r.status == fcm_pkg::ST_OK) chain_tail[idx] = r.blk;
                end else begin
                    send_req(fcm_pkg::OP_ALLOC, any_block(), any_block(), 1'b0, r);
                    if (r.status == fcm_pkg::ST_OK) begin
                        chain_head.push_back(r.blk);
                        chain_tail.push_back(r.blk);
                    end
                end
            end else if (pick < 50) begin
                send_req(fcm_pkg::OP_ALLOC, any_block(), any_block(), 1'b1, r);  // random prev
            end else if (pick < 72) begin
                if (idx >= 0 && $urandom_range(0, 9) < 8) begin
                    send_req(fcm_pkg::OP_FREE, fcm_pkg::BLK_W'(chain_head[idx]), any_block(),
                             1'($urandom), r);
                    chain_head.delete(idx);
                    chain_tail.delete(idx);
                end else begin
                    send_req(fcm_pkg::OP_FREE, any_block(), any_block(), 1'($urandom), r);
                end
            end else begin
                if (idx >= 0 && $urandom_range(0, 1) == 0)
                    send_req(fcm_pkg::OP_LOOKUP, fcm_pkg::BLK_W'(chain_head[idx]), any_block(),
                             1'($urandom), r);
                else
                    send_req(fcm_pkg::OP_LOOKUP, any_block(), any_block(), 1'($urandom), r);
            end
        end
        drain();
    endtask

    initial begin
        format_model();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_special_cases();
        test_random_traffic(500);
        test_long_chain();
        test_random_traffic(480);
        if (mismatches == 0)
            $display("[fat_chain_manager] OK");
        else
            $display("[fat_chain_manager] ERROR");
        $finish;
    end

    initial begin
        #400_000_000;
        $display("[fat_chain_manager] ERROR");
        $finish;
    end

endmodule
